/* design/dmix_pkg.sv */
`timescale 1ns / 1ps

package dmix_pkg;

   // Duty range and face mode step
   localparam logic [8:0] DUTY_MAX  = 9'd400;
   localparam logic [8:0] FACE_STEP = 9'd50;

   // Joystick thresholds
   localparam logic [11:0] Y_FWD_START   = 12'd2100;
   localparam logic [11:0] Y_REV_START   = 12'd1900;
   localparam logic [11:0] X_LEFT_START  = 12'd1900;
   localparam logic [11:0] X_RIGHT_START = 12'd2150;
   localparam int unsigned ADC_SPAN      = 4096;

   // Scaling d*400/D is done as (d * RECIP) >> RECIP_SHIFT with RECIP rounded up;
   // exact for every d below 2**RECIP_SHIFT / D, which covers the 12-bit range.
   localparam int unsigned RECIP_SHIFT = 23;
   localparam int unsigned RECIP_W     = 21;
   localparam logic [63:0] SCALED_MAX  = 64'd400 << RECIP_SHIFT;
   localparam logic [63:0] DIV_Y_FWD   = 64'(ADC_SPAN) - 64'(Y_FWD_START);
   localparam logic [63:0] DIV_LOW     = 64'(Y_REV_START);
   localparam logic [63:0] DIV_X_RIGHT = 64'(ADC_SPAN) - 64'(X_RIGHT_START);
   localparam logic [RECIP_W-1:0] RECIP_Y_FWD =
      RECIP_W'((SCALED_MAX + DIV_Y_FWD - 64'd1) / DIV_Y_FWD);
   localparam logic [RECIP_W-1:0] RECIP_LOW =
      RECIP_W'((SCALED_MAX + DIV_LOW - 64'd1) / DIV_LOW);
   localparam logic [RECIP_W-1:0] RECIP_X_RIGHT =
      RECIP_W'((SCALED_MAX + DIV_X_RIGHT - 64'd1) / DIV_X_RIGHT);

   // Command bytes
   localparam logic [7:0] CMD_F = 8'h46;
   localparam logic [7:0] CMD_R = 8'h52;
   localparam logic [7:0] CMD_L = 8'h4C;
   localparam logic [7:0] CMD_C = 8'h43;
   localparam logic [7:0] CMD_T = 8'h54;
   localparam logic [7:0] CMD_S = 8'h53;
   localparam logic [7:0] CMD_N = 8'h4E;

   // Pin patterns: {left_neg, left_pos, right_neg, right_pos}
   localparam logic [3:0] PINS_STOP  = 4'b0000;
   localparam logic [3:0] PINS_FWD   = 4'b0101;
   localparam logic [3:0] PINS_REV   = 4'b1010;
   localparam logic [3:0] PINS_LEFT  = 4'b0001;
   localparam logic [3:0] PINS_RIGHT = 4'b0100;

   // Register word indexes
   localparam logic REG_DRIVE_MODE  = 1'b0;
   localparam logic REG_CRUISE_DUTY = 1'b1;

   localparam logic       DRIVE_MODE_RESET  = 1'b1;
   localparam logic [8:0] CRUISE_DUTY_RESET = 9'd300;

   typedef struct packed {
      logic [11:0] joy_y;
      logic [11:0] joy_x;
      logic [7:0]  cmd_byte;
   } req_type;

   typedef struct packed {
      logic [8:0] right_duty;
      logic [8:0] left_duty;
      logic       right_pos;
      logic       right_neg;
      logic       left_pos;
      logic       left_neg;
      logic       going_forward;
      logic       toggle_flag;
   } rsp_type;

endpackage

/* design/differential_drive_mixer_top.sv */
`timescale 1ns / 1ps

// Channel   Ports                                    Direction  Handshake
// request   req_valid, req_stall, req_payload        in         valid / stall
// response  rsp_valid, rsp_stall, rsp_payload        out        valid / stall
// csr       csr_psel .. csr_prdata, csr_pready       in / out   APB, pready always high
//
// One transaction per cycle sustained while rsp_stall stays low: the joystick axes
// are scaled into the input register, then the mix or the command machine
// writes the held state, which is the response register.
// Reset is synchronous: duties 0, pins low, forward flag 0, toggle flag 1,
// drive_mode 1, cruise_duty 300.
// A stalled response holds the input register; req_stall rises only when it is full.

module differential_drive_mixer_top (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  dmix_pkg::req_type   req_payload,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output dmix_pkg::rsp_type   rsp_payload,
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [2:0]          csr_paddr,
   input  logic [31:0]         csr_pwdata,
   output logic [31:0]         csr_prdata,
   output logic                csr_pready
);

   typedef struct packed {
      logic [3:0] pins;
      logic [8:0] base;
      logic       turn_left;
      logic       turn_right;
      logic [8:0] turn;
      logic [7:0] cmd;
   } stage_type;

   localparam int unsigned PROD_W = 11 + dmix_pkg::RECIP_W;

   logic       drive_mode_ff;
   logic [8:0] cruise_duty_ff;
   logic       csr_write;

   logic       in_vld_ff, in_vld_in;
   stage_type  stage_ff, stage_in;
   logic       out_vld_ff, out_vld_in;
   logic       advance;

   logic [8:0] r_duty_ff, r_duty_in;
   logic [8:0] l_duty_ff, l_duty_in;
   logic [3:0] pins_ff, pins_in;
   logic       fwd_ff, fwd_in;
   logic       tog_ff, tog_in;

   logic                        y_fwd, y_rev;
   logic [11:0]                 y_diff, x_diff;
   logic [dmix_pkg::RECIP_W-1:0] y_recip, x_recip;
   logic [PROD_W-1:0]           y_prod, x_prod;
   logic                        x_left, x_right;

   logic [8:0]  man_r, man_l;
   logic [3:0]  man_pins;
   logic [10:0] r_sum;
   logic [9:0]  l_sum, twice_m;
   logic [8:0]  face_s, face_lo, face_hi;
   logic [9:0]  face_sum;

   // Configuration port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         drive_mode_ff  <= dmix_pkg::DRIVE_MODE_RESET;
         cruise_duty_ff <= dmix_pkg::CRUISE_DUTY_RESET;
      end else if (csr_write) begin
         unique case (csr_paddr[2])
            dmix_pkg::REG_DRIVE_MODE:  drive_mode_ff  <= csr_pwdata[0];
            dmix_pkg::REG_CRUISE_DUTY: cruise_duty_ff <= csr_pwdata[8:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         dmix_pkg::REG_DRIVE_MODE:  csr_prdata = {31'd0, drive_mode_ff};
         dmix_pkg::REG_CRUISE_DUTY: csr_prdata = {23'd0, cruise_duty_ff};
         default:                   csr_prdata = 32'd0;
      endcase
   end

   // Handshake: advance when the response register is free or being taken
   assign advance    = in_vld_ff && (!out_vld_ff || !rsp_stall);
   assign req_stall  = in_vld_ff && !advance;
   assign in_vld_in  = (req_valid && !req_stall) ? 1'b1 : (advance ? 1'b0 : in_vld_ff);
   assign out_vld_in = advance ? 1'b1 : (rsp_stall ? out_vld_ff : 1'b0);

   // Scale the Y axis into a base speed
   always_comb begin
      y_fwd   = req_payload.joy_y >= dmix_pkg::Y_FWD_START;
      y_rev   = req_payload.joy_y <= dmix_pkg::Y_REV_START;
      y_diff  = y_fwd ? req_payload.joy_y - dmix_pkg::Y_FWD_START
                      : dmix_pkg::Y_REV_START - req_payload.joy_y;
      y_recip = y_fwd ? dmix_pkg::RECIP_Y_FWD : dmix_pkg::RECIP_LOW;
      y_prod  = PROD_W'(y_diff[10:0]) * PROD_W'(y_recip);
   end

   // Scale the X axis into a turn amount
   always_comb begin
      x_left  = req_payload.joy_x < dmix_pkg::X_LEFT_START;
      x_right = req_payload.joy_x > dmix_pkg::X_RIGHT_START;
      x_diff  = x_left ? dmix_pkg::X_LEFT_START - req_payload.joy_x
                       : req_payload.joy_x - dmix_pkg::X_RIGHT_START;
      x_recip = x_left ? dmix_pkg::RECIP_LOW : dmix_pkg::RECIP_X_RIGHT;
      x_prod  = PROD_W'(x_diff[10:0]) * PROD_W'(x_recip);
   end

   always_comb begin
      stage_in.pins       = y_fwd ? dmix_pkg::PINS_FWD
                          : (y_rev ? dmix_pkg::PINS_REV : dmix_pkg::PINS_STOP);
      stage_in.base       = (y_fwd || y_rev) ?
                            y_prod[dmix_pkg::RECIP_SHIFT +: 9] : 9'd0;
      stage_in.turn_left  = x_left;
      stage_in.turn_right = x_right;
      stage_in.turn       = x_prod[dmix_pkg::RECIP_SHIFT +: 9];
      stage_in.cmd        = req_payload.cmd_byte;
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
      end
      if (req_valid && !req_stall) begin
         stage_ff <= stage_in;
      end
   end

   // Mix the turn into the base speed
   always_comb begin
      r_sum   = {2'd0, stage_ff.base} + {1'b0, stage_ff.turn, 1'b0};
      twice_m = {stage_ff.turn, 1'b0};
      l_sum   = {1'b0, stage_ff.base} + {1'b0, stage_ff.turn};
      man_r    = stage_ff.base;
      man_l    = stage_ff.base;
      man_pins = stage_ff.pins;
      if (stage_ff.turn_left) begin
         man_r    = (r_sum > 11'(dmix_pkg::DUTY_MAX)) ? dmix_pkg::DUTY_MAX : r_sum[8:0];
         man_l    = (stage_ff.base > stage_ff.turn) ? stage_ff.base - stage_ff.turn : 9'd0;
         man_pins = dmix_pkg::PINS_LEFT;
      end else if (stage_ff.turn_right) begin
         man_r    = ({1'b0, stage_ff.base} > twice_m) ?
                    9'({1'b0, stage_ff.base} - twice_m) : 9'd0;
         man_l    = (l_sum > 10'(dmix_pkg::DUTY_MAX)) ? dmix_pkg::DUTY_MAX : l_sum[8:0];
         man_pins = dmix_pkg::PINS_RIGHT;
      end
   end

   // Face mode speeds, saturated to the duty range
   always_comb begin
      face_s   = (cruise_duty_ff > dmix_pkg::DUTY_MAX) ? dmix_pkg::DUTY_MAX : cruise_duty_ff;
      face_lo  = (face_s > dmix_pkg::FACE_STEP) ? face_s - dmix_pkg::FACE_STEP : 9'd0;
      face_sum = {1'b0, face_s} + {1'b0, dmix_pkg::FACE_STEP};
      face_hi  = (face_sum > 10'(dmix_pkg::DUTY_MAX)) ? dmix_pkg::DUTY_MAX : face_sum[8:0];
   end

   // Next held state
   always_comb begin
      r_duty_in = r_duty_ff;
      l_duty_in = l_duty_ff;
      pins_in   = pins_ff;
      fwd_in    = fwd_ff;
      tog_in    = tog_ff;
      if (!drive_mode_ff) begin
         r_duty_in = man_r;
         l_duty_in = man_l;
         pins_in   = man_pins;
      end else begin
         unique case (stage_ff.cmd) inside
            dmix_pkg::CMD_F: begin
               r_duty_in = face_s;
               l_duty_in = face_s;
               pins_in   = dmix_pkg::PINS_FWD;
               fwd_in    = 1'b1;
            end
            dmix_pkg::CMD_R: begin
               r_duty_in = fwd_ff ? face_lo : face_s;
               l_duty_in = fwd_ff ? face_hi : face_s;
               pins_in   = fwd_ff ? dmix_pkg::PINS_FWD : dmix_pkg::PINS_RIGHT;
            end
            dmix_pkg::CMD_L: begin
               r_duty_in = fwd_ff ? face_hi : face_s;
               l_duty_in = fwd_ff ? face_lo : face_s;
               pins_in   = fwd_ff ? dmix_pkg::PINS_FWD : dmix_pkg::PINS_LEFT;
            end
            dmix_pkg::CMD_C: begin
               r_duty_in = fwd_ff ? face_s : 9'd0;
               l_duty_in = fwd_ff ? face_s : 9'd0;
               pins_in   = fwd_ff ? dmix_pkg::PINS_FWD : dmix_pkg::PINS_STOP;
            end
            dmix_pkg::CMD_T: begin
               r_duty_in = 9'd0;
               l_duty_in = 9'd0;
               pins_in   = dmix_pkg::PINS_STOP;
               fwd_in    = 1'b0;
               tog_in    = !tog_ff;
            end
            dmix_pkg::CMD_S, dmix_pkg::CMD_N: begin
               r_duty_in = 9'd0;
               l_duty_in = 9'd0;
               pins_in   = dmix_pkg::PINS_STOP;
               fwd_in    = 1'b0;
            end
            default: ;
         endcase
      end
   end

   // Held state doubles as the response register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
         r_duty_ff  <= 9'd0;
         l_duty_ff  <= 9'd0;
         pins_ff    <= dmix_pkg::PINS_STOP;
         fwd_ff     <= 1'b0;
         tog_ff     <= 1'b1;
      end else begin
         out_vld_ff <= out_vld_in;
         if (advance) begin
            r_duty_ff <= r_duty_in;
            l_duty_ff <= l_duty_in;
            pins_ff   <= pins_in;
            fwd_ff    <= fwd_in;
            tog_ff    <= tog_in;
         end
      end
   end

   assign rsp_valid                 = out_vld_ff;
   assign rsp_payload.right_duty    = r_duty_ff;
   assign rsp_payload.left_duty     = l_duty_ff;
   assign rsp_payload.right_pos     = pins_ff[0];
   assign rsp_payload.right_neg     = pins_ff[1];
   assign rsp_payload.left_pos      = pins_ff[2];
   assign rsp_payload.left_neg      = pins_ff[3];
   assign rsp_payload.going_forward = fwd_ff;
   assign rsp_payload.toggle_flag   = tog_ff;

   // Duties stay inside the PWM period
   a_duty_range: assert property (@(posedge clock) disable iff (reset)
      (r_duty_ff <= dmix_pkg::DUTY_MAX) && (l_duty_ff <= dmix_pkg::DUTY_MAX))
      else $error("duty beyond PWM period");

   // Never drive both sides of one bridge
   a_no_shoot_through: assert property (@(posedge clock) disable iff (reset)
      !(pins_ff[0] && pins_ff[1]) && !(pins_ff[2] && pins_ff[3]))
      else $error("both pins of one motor high");

   // Held state moves only with a transaction leaving the input register
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(tog_ff) && $stable(fwd_ff) && $stable(pins_ff))
      else $error("held state changed without a transaction");

   // Stall only while the input register is full
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_vld_ff && out_vld_ff && rsp_stall)
      else $error("request stalled without backpressure");

endmodule

/* tb/differential_drive_mixer_top_tb.sv */
`timescale 1ns / 1ps

module differential_drive_mixer_top_tb;
   import dmix_pkg::*;

   // Predicts each output transaction and checks it against what the mixer returns
   class drive_checker;
      logic        mode;
      logic [8:0]  speed;
      logic [8:0]  right_duty;
      logic [8:0]  left_duty;
      logic [3:0]  pins;
      logic        fwd;
      logic        tgl;
      rsp_type     expected_drive[$];
      int unsigned errors;

      function new();
         mode       = DRIVE_MODE_RESET;
         speed      = CRUISE_DUTY_RESET;
         right_duty = '0;
         left_duty  = '0;
         pins       = PINS_STOP;
         fwd        = 1'b0;
         tgl        = 1'b1;
         errors     = 0;
      endfunction

      function void set_register(logic idx, logic [31:0] value);
         if (idx == REG_DRIVE_MODE)
            mode = value[0];
         else
            speed = value[8:0];
      endfunction

      function int unsigned pending();
         return expected_drive.size();
      endfunction

      // Advance the held drive state by one request and queue the outputs
      function void predict_drive(req_type item);
         int unsigned y, x, r, l, m, s, lo, hi;
         rsp_type     want;
         y = item.joy_y;
         x = item.joy_x;
         r = right_duty;
         l = left_duty;
         if (mode == 1'b0) begin
            // forward/reverse speed from the Y axis, dead zone stops
            if (y >= Y_FWD_START) begin
               pins = PINS_FWD;
               r = (y - Y_FWD_START) * DUTY_MAX / (ADC_SPAN - Y_FWD_START);
               l = r;
            end else if (y <= Y_REV_START) begin
               pins = PINS_REV;
               r = (Y_REV_START - y) * DUTY_MAX / Y_REV_START;
               l = r;
            end else begin
               pins = PINS_STOP;
               r = 0;
               l = 0;
            end
            // mix in the turn from the X axis
            if (x < X_LEFT_START) begin
               m = (X_LEFT_START - x) * DUTY_MAX / X_LEFT_START;
               r = (r + 2 * m > DUTY_MAX) ? DUTY_MAX : r + 2 * m;
               l = (l > m) ? l - m : 0;
               pins = PINS_LEFT;
            end else if (x > X_RIGHT_START) begin
               m = (x - X_RIGHT_START) * DUTY_MAX / (ADC_SPAN - X_RIGHT_START);
               r = (r > 2 * m) ? r - 2 * m : 0;
               l = (l + m > DUTY_MAX) ? DUTY_MAX : l + m;
               pins = PINS_RIGHT;
            end
         end else begin
            s  = (speed > DUTY_MAX) ? DUTY_MAX : speed;
            lo = (s > FACE_STEP) ? s - FACE_STEP : 0;
            hi = (s + FACE_STEP > DUTY_MAX) ? DUTY_MAX : s + FACE_STEP;
            case (item.cmd_byte)
               CMD_F: begin
                  r = s;
                  l = s;
                  pins = PINS_FWD;
                  fwd = 1'b1;
               end
               CMD_R: begin
                  if (fwd) begin
                     r = lo;
                     l = hi;
                     pins = PINS_FWD;
                  end else begin
                     r = s;
                     l = s;
                     pins = PINS_RIGHT;
                  end
               end
               CMD_L: begin
                  if (fwd) begin
                     r = hi;
                     l = lo;
                     pins = PINS_FWD;
                  end else begin
                     r = s;
                     l = s;
                     pins = PINS_LEFT;
                  end
               end
               CMD_C: begin
                  if (fwd) begin
                     r = s;
                     l = s;
                     pins = PINS_FWD;
                  end else begin
                     r = 0;
                     l = 0;
                     pins = PINS_STOP;
                  end
               end
               CMD_T: begin
                  tgl = ~tgl;
                  fwd = 1'b0;
                  r = 0;
                  l = 0;
                  pins = PINS_STOP;
               end
               CMD_S, CMD_N: begin
                  fwd = 1'b0;
                  r = 0;
                  l = 0;
                  pins = PINS_STOP;
               end
               // any other byte holds everything
               default: ;
            endcase
         end
         right_duty = r[8:0];
         left_duty  = l[8:0];

         want.right_duty    = right_duty;
         want.left_duty     = left_duty;
         want.right_pos     = pins[0];
         want.right_neg     = pins[1];
         want.left_pos      = pins[2];
         want.left_neg      = pins[3];
         want.going_forward = fwd;
         want.toggle_flag   = tgl;
         expected_drive.push_back(want);
      endfunction

      function void compare_field(string field, int unsigned want, int unsigned got);
         if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            errors++;
         end
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         if (expected_drive.size() == 0) begin
            $display("%0t: output transaction with none expected, expected nothing, actual %h",
                     $time, got);
            errors++;
         end else begin
            want = expected_drive.pop_front();
            compare_field("right_duty", want.right_duty, got.right_duty);
            compare_field("left_duty", want.left_duty, got.left_duty);
            compare_field("right_pos", want.right_pos, got.right_pos);
            compare_field("right_neg", want.right_neg, got.right_neg);
            compare_field("left_pos", want.left_pos, got.left_pos);
            compare_field("left_neg", want.left_neg, got.left_neg);
            compare_field("going_forward", want.going_forward, got.going_forward);
            compare_field("toggle_flag", want.toggle_flag, got.toggle_flag);
         end
      endfunction
   endclass

   logic        clock;
   logic        reset       = 1'b1;
   logic        req_valid   = 1'b0;
   logic        req_stall;
   req_type     req_payload = '0;
   logic        rsp_valid;
   logic        rsp_stall   = 1'b0;
   rsp_type     rsp_payload;
   logic        csr_psel    = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite  = 1'b0;
   logic [2:0]  csr_paddr   = '0;
   logic [31:0] csr_pwdata  = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   drive_checker board;
   bit           calm = 1'b0;
   int unsigned  hold_count = 0;

   logic        phase_mode  [8] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1};
   int unsigned phase_speed [8] = '{300, 511, 0, 0, 25, 137, 400, 455};

   differential_drive_mixer_top uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Stall the output channel in bursts: mostly short, a few long
   always @(posedge clock) begin
      if (reset || calm) begin
         rsp_stall <= 1'b0;
      end else if (hold_count > 0) begin
         hold_count <= hold_count - 1;
      end else if (rsp_stall) begin
         rsp_stall  <= 1'b0;
         hold_count <= $urandom_range(0, 12);
      end else if ($urandom_range(0, 2) == 0) begin
         rsp_stall  <= 1'b1;
         hold_count <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30)
                                                   : $urandom_range(0, 2);
      end
   end

   // Sample the output channel mid-cycle, check at the edge that takes the transaction
   initial begin
      logic    seen_valid;
      logic    seen_stall;
      rsp_type seen_payload;
      forever begin
         @(negedge clock);
         seen_valid   = rsp_valid;
         seen_stall   = rsp_stall;
         seen_payload = rsp_payload;
         @(posedge clock);
         if (!reset && seen_valid && !seen_stall)
            board.check_response(seen_payload);
      end
   end

   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (calm || roll < 55)
         return 0;
      else if (roll < 90)
         return $urandom_range(1, 3);
      else
         return $urandom_range(8, 40);
   endfunction

   function automatic logic [11:0] random_axis(input int unsigned near_lo, near_hi);
      if ($urandom_range(0, 3) == 0)
         return 12'($urandom_range(near_lo, near_hi));
      else
         return 12'($urandom);
   endfunction

   function automatic req_type random_face_item();
      req_type     item;
      int unsigned pick;
      item.joy_y = 12'($urandom);
      item.joy_x = 12'($urandom);
      pick = $urandom_range(0, 19);
      if (pick < 4)
         item.cmd_byte = CMD_F;
      else if (pick < 8)
         item.cmd_byte = CMD_R;
      else if (pick < 12)
         item.cmd_byte = CMD_L;
      else if (pick < 14)
         item.cmd_byte = CMD_C;
      else if (pick == 14)
         item.cmd_byte = CMD_T;
      else if (pick == 15)
         item.cmd_byte = CMD_S;
      else if (pick == 16)
         item.cmd_byte = CMD_N;
      else
         item.cmd_byte = 8'($urandom);
      return item;
   endfunction

   function automatic req_type random_manual_item();
      req_type item;
      item.joy_y    = random_axis(1890, 2110);
      item.joy_x    = random_axis(1890, 2160);
      item.cmd_byte = 8'($urandom);
      return item;
   endfunction

   // Present one transaction after a random gap and hold it until taken
   task automatic send_request(input req_type item);
      int unsigned gap;
      logic        stall_seen;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      do begin
         @(negedge clock);
         stall_seen = req_stall;
         @(posedge clock);
      end while (stall_seen);
      board.predict_drive(item);
   endtask

   task automatic send_fields(input logic [11:0] y, input logic [11:0] x,
                              input logic [7:0] cmd);
      req_type item;
      item.joy_y    = y;
      item.joy_x    = x;
      item.cmd_byte = cmd;
      send_request(item);
   endtask

   // Drop valid and hold off until every output transaction is back
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_register(input logic idx, input logic [31:0] value);
      logic ready_seen;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do begin
         @(negedge clock);
         ready_seen = csr_pready;
         @(posedge clock);
      end while (!ready_seen);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      board.set_register(idx, value);
      @(posedge clock);
   endtask

   // Write both registers; upper bits carry noise that must be dropped
   task automatic configure(input logic mode, input logic [8:0] speed);
      write_register(REG_DRIVE_MODE, ($urandom & ~32'h1) | 32'(mode));
      write_register(REG_CRUISE_DUTY, ($urandom & ~32'h1FF) | 32'(speed));
   endtask

   initial begin
      board = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // face mode at reset settings: every command but S, turns with and without forward
      send_fields(12'd0,    12'd4095, CMD_F);
      send_fields(12'd4095, 12'd0,    CMD_R);
      send_fields(12'd2000, 12'd2000, CMD_L);
      send_fields(12'd2000, 12'd2000, CMD_C);
      send_fields(12'd2000, 12'd2000, CMD_T);
      send_fields(12'd2000, 12'd2000, CMD_R);
      send_fields(12'd2000, 12'd2000, CMD_L);
      send_fields(12'd2000, 12'd2000, CMD_C);
      send_fields(12'd2000, 12'd2000, 8'h00);
      send_fields(12'd2000, 12'd2000, CMD_F);
      send_fields(12'd2000, 12'd2000, 8'hFF);
      send_fields(12'd2000, 12'd2000, CMD_N);

      // manual mode: axis extremes and dead zone edges
      wait_idle();
      configure(1'b0, 9'd300);
      send_fields(12'd4095, 12'd2000, 8'h00);
      send_fields(12'd0,    12'd2000, 8'hFF);
      send_fields(12'd2100, 12'd2000, CMD_F);
      send_fields(12'd2099, 12'd2000, CMD_F);
      send_fields(12'd1901, 12'd1900, CMD_T);
      send_fields(12'd1900, 12'd2150, CMD_S);
      send_fields(12'd2000, 12'd0,    CMD_L);
      send_fields(12'd2000, 12'd4095, CMD_R);
      send_fields(12'd4095, 12'd0,    8'h00);
      send_fields(12'd0,    12'd4095, 8'h00);
      send_fields(12'd4095, 12'd4095, 8'h00);
      send_fields(12'd1900, 12'd1899, 8'h00);
      send_fields(12'd2100, 12'd2151, 8'h00);

      // random phases across modes and speeds, some without any idling
      for (int p = 0; p < 8; p++) begin
         wait_idle();
         calm = (p == 3 || p == 6);
         configure(phase_mode[p], 9'(phase_speed[p]));
         for (int n = 0; n < 82; n++) begin
            if (p == 1 && n == 40)
               wait_idle();
            if (phase_mode[p])
               send_request(random_face_item());
            else
               send_request(random_manual_item());
         end
      end

      wait_idle();
      repeat (8) @(posedge clock);
      if (board.errors == 0 && board.pending() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      #20_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

/* sim.f */
design/dmix_pkg.sv
design/differential_drive_mixer_top.sv
tb/differential_drive_mixer_top_tb.sv
